### rtl/core/pwcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcb_pkg
// Shared types and constants of the pixel write, clip and blend block.
// ----------------------------------------------------------------------------
package pwcb_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_ROW_PITCH     = 3'd2;
    localparam logic [2:0] REG_CLIP_LEFT     = 3'd3;
    localparam logic [2:0] REG_CLIP_TOP      = 3'd4;
    localparam logic [2:0] REG_CLIP_WIDTH    = 3'd5;
    localparam logic [2:0] REG_CLIP_HEIGHT   = 3'd6;
    localparam logic [2:0] REG_MODE_BITS     = 3'd7;

    localparam int MODE_CLIP  = 0;
    localparam int MODE_BLEND = 1;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;
    localparam logic [31:0] OPAQUE_MASK  = 32'hFF00_0000;

    typedef enum logic [1:0] {
        KIND_DROP,
        KIND_PASS,
        KIND_DEST,
        KIND_MIX
    } t_kind;

    typedef struct packed {
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [13:0] row_pitch;
        logic [15:0] clip_left;
        logic [15:0] clip_top;
        logic [15:0] clip_width;
        logic [15:0] clip_height;
        logic [1:0]  mode_bits;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [12:0] col;
        logic [12:0] row;
        logic [13:0] pitch;
        logic [31:0] src;
        logic [31:0] dest;
    } t_item;

endpackage

### rtl/core/pwcb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcb_front
// Accept pixel write words, test screen bounds and clip rectangle, and
// classify each word for the back end.
// ----------------------------------------------------------------------------
module pwcb_front #(
    parameter int MAX_DIM   = 4096,
    parameter int MAX_PITCH = 8192
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pwcb_pkg::t_cfg   i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [15:0]      i_pos_x,
    input  logic [15:0]      i_pos_y,
    input  logic [31:0]      i_src_color,
    input  logic [31:0]      i_dest_pixel,
    output logic             o_valid,
    input  logic             i_ready,
    output pwcb_pkg::t_item  o_item
);

    localparam logic [15:0] MaxDim   = 16'(MAX_DIM);
    localparam logic [15:0] MaxPitch = 16'(MAX_PITCH);

    logic            r_valid;
    pwcb_pkg::t_item r_item;
    logic            n_valid;
    pwcb_pkg::t_item n_item;

    logic [15:0] w_width;
    logic [15:0] w_height;
    logic [13:0] w_pitch;
    logic [16:0] w_x;
    logic [16:0] w_y;
    logic [16:0] w_cl;
    logic [16:0] w_ct;
    logic [16:0] w_cr;
    logic [16:0] w_cb;
    logic        w_in_screen;
    logic        w_in_clip;
    logic        w_keep;
    logic [7:0]  w_alpha;
    logic        w_accept;

    always_comb begin
        w_width  = ({3'b000, i_cfg.screen_width} > MaxDim) ? MaxDim
                                                          : {3'b000, i_cfg.screen_width};
        w_height = ({3'b000, i_cfg.screen_height} > MaxDim) ? MaxDim
                                                           : {3'b000, i_cfg.screen_height};
        w_pitch  = ({2'b00, i_cfg.row_pitch} > MaxPitch) ? MaxPitch[13:0] : i_cfg.row_pitch;

        w_x  = {i_pos_x[15], i_pos_x};
        w_y  = {i_pos_y[15], i_pos_y};
        w_cl = {i_cfg.clip_left[15], i_cfg.clip_left};
        w_ct = {i_cfg.clip_top[15], i_cfg.clip_top};
        w_cr = w_cl + {i_cfg.clip_width[15], i_cfg.clip_width};
        w_cb = w_ct + {i_cfg.clip_height[15], i_cfg.clip_height};

        w_in_screen = !i_pos_x[15] && !i_pos_y[15]
                   && ({1'b0, i_pos_x[14:0]} < w_width)
                   && ({1'b0, i_pos_y[14:0]} < w_height);
        w_in_clip   = ($signed(w_x) >= $signed(w_cl)) && ($signed(w_x) < $signed(w_cr))
                   && ($signed(w_y) >= $signed(w_ct)) && ($signed(w_y) < $signed(w_cb));
        w_keep      = w_in_screen && (!i_cfg.mode_bits[pwcb_pkg::MODE_CLIP] || w_in_clip);
        w_alpha     = i_src_color[31:24];
    end

    always_comb begin
        n_item.col   = i_pos_x[12:0];
        n_item.row   = i_pos_y[12:0];
        n_item.pitch = w_pitch;
        n_item.src   = i_src_color;
        n_item.dest  = i_dest_pixel;
        if (!w_keep) begin
            n_item.kind = pwcb_pkg::KIND_DROP;
        end else if (!i_cfg.mode_bits[pwcb_pkg::MODE_BLEND]
                     || w_alpha == pwcb_pkg::ALPHA_OPAQUE) begin
            n_item.kind = pwcb_pkg::KIND_PASS;
        end else if (w_alpha == pwcb_pkg::ALPHA_CLEAR) begin
            n_item.kind = pwcb_pkg::KIND_DEST;
        end else begin
            n_item.kind = pwcb_pkg::KIND_MIX;
        end
    end

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/core/pwcb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcb_queue
// Short register queue between the classify front end and the blend back end.
// ----------------------------------------------------------------------------
module pwcb_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  pwcb_pkg::t_item  i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output pwcb_pkg::t_item  o_item
);

    localparam logic [pwcb_pkg::QPTR_W:0] Depth = (pwcb_pkg::QPTR_W + 1)'(pwcb_pkg::QUEUE_DEPTH);

    pwcb_pkg::t_item                r_mem [pwcb_pkg::QUEUE_DEPTH];
    logic [pwcb_pkg::QPTR_W-1:0]    r_wr;
    logic [pwcb_pkg::QPTR_W-1:0]    r_rd;
    logic [pwcb_pkg::QPTR_W:0]      r_count;
    logic [pwcb_pkg::QPTR_W:0]      n_count;
    logic                           w_full;
    logic                           w_push;
    logic                           w_pop;

    assign w_full  = (r_count == Depth);
    assign o_ready = !w_full;
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_valid && !w_full;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Depth)
        else $error("queue count above depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == Depth) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with count");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");
`endif

endmodule

### rtl/core/pwcb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcb_back
// Form the word address and the stored word: multiply stage, then sum,
// divide by 255 and select into the output register.
// ----------------------------------------------------------------------------
module pwcb_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  pwcb_pkg::t_item  i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_write_enable,
    output logic [24:0]      o_word_address,
    output logic [31:0]      o_write_data
);

    logic               r_s1_valid;
    pwcb_pkg::t_kind    r_s1_kind;
    logic [12:0]        r_s1_col;
    logic [26:0]        r_s1_row_base;
    logic [15:0]        r_s1_fg [3];
    logic [15:0]        r_s1_bg [3];
    logic [31:0]        r_s1_src;
    logic [31:0]        r_s1_dest;

    logic               r_o_valid;
    logic               r_o_we;
    logic [24:0]        r_o_addr;
    logic [31:0]        r_o_data;

    logic               n_o_we;
    logic [24:0]        n_o_addr;
    logic [31:0]        n_o_data;

    logic               w_advance;
    logic [7:0]         w_alpha;
    logic [7:0]         w_inv_alpha;
    logic [7:0]         w_mix [3];
    logic [16:0]        w_sum [3];
    logic [16:0]        w_quo [3];
    logic [27:0]        w_addr;

    assign w_advance   = !r_o_valid || i_ready;
    assign o_ready     = w_advance;
    assign w_alpha     = i_item.src[31:24];
    assign w_inv_alpha = pwcb_pkg::ALPHA_OPAQUE - w_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (w_advance) begin
            r_s1_valid <= i_valid;
            r_o_valid  <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s1_kind     <= i_item.kind;
            r_s1_col      <= i_item.col;
            r_s1_row_base <= 27'(i_item.row * i_item.pitch);
            r_s1_src      <= i_item.src;
            r_s1_dest     <= i_item.dest;
            for (int c = 0; c < 3; c++) begin
                r_s1_fg[c] <= i_item.src[c*8 +: 8] * w_alpha;
                r_s1_bg[c] <= i_item.dest[c*8 +: 8] * w_inv_alpha;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = {1'b0, r_s1_fg[c]} + {1'b0, r_s1_bg[c]};
            w_quo[c] = w_sum[c] + {9'd0, w_sum[c][15:8]} + 17'd1;
            w_mix[c] = w_quo[c][15:8];
        end
        w_addr = {1'b0, r_s1_row_base} + {15'd0, r_s1_col};
    end

    always_comb begin
        n_o_we   = 1'b1;
        n_o_addr = w_addr[24:0];
        case (r_s1_kind)
            pwcb_pkg::KIND_DROP: begin
                n_o_we   = 1'b0;
                n_o_addr = '0;
                n_o_data = '0;
            end
            pwcb_pkg::KIND_PASS: begin
                n_o_data = r_s1_src;
            end
            pwcb_pkg::KIND_DEST: begin
                n_o_data = r_s1_dest;
            end
            pwcb_pkg::KIND_MIX: begin
                n_o_data = pwcb_pkg::OPAQUE_MASK | {8'd0, w_mix[2], w_mix[1], w_mix[0]};
            end
            default: begin
                n_o_we   = 1'b0;
                n_o_addr = '0;
                n_o_data = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_o_we   <= n_o_we;
            r_o_addr <= n_o_addr;
            r_o_data <= n_o_data;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_write_enable = r_o_we;
    assign o_word_address = r_o_addr;
    assign o_write_data   = r_o_data;

endmodule

### rtl/core/pixel_write_clip_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_write_clip_blend
// Pixel write requests in, framebuffer writes out: screen bounds, optional
// clip rectangle and optional ARGB8888 source-over blend.
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      pos_x, pos_y, src_color, dest_pixel
//   m_axis    out  m_axis_tvalid/tready      tuser write_enable; word_address, write_data
//   apb       in   psel/penable/pwrite       8 registers at 4*index
//
// One word per cycle sustained while m_axis_tready is high; four register
// stages (classify register, queue, multiply stage, output register), which
// a write word passes in that order once its request is accepted.
// Reset is synchronous; all registers read 0 after it.
// A stalled output holds the back end; the 4-entry queue and the front
// register absorb words until it fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module pixel_write_clip_blend #(
    parameter int MAX_DIM   = 4096,
    parameter int MAX_PITCH = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // pos_x, pos_y, src_color, dest_pixel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // word_address, write_data, zero pad
    output logic        m_axis_tuser,   // write_enable
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pwcb_pkg::t_cfg  r_cfg;
    logic            w_cfg_wr;
    logic [2:0]      w_reg_idx;

    logic            w_f_valid;
    logic            w_f_ready;
    pwcb_pkg::t_item w_f_item;
    logic            w_q_valid;
    logic            w_q_ready;
    pwcb_pkg::t_item w_q_item;
    logic            w_we;
    logic [24:0]     w_addr;
    logic [31:0]     w_data;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                pwcb_pkg::REG_SCREEN_WIDTH:  r_cfg.screen_width  <= pwdata[12:0];
                pwcb_pkg::REG_SCREEN_HEIGHT: r_cfg.screen_height <= pwdata[12:0];
                pwcb_pkg::REG_ROW_PITCH:     r_cfg.row_pitch     <= pwdata[13:0];
                pwcb_pkg::REG_CLIP_LEFT:     r_cfg.clip_left     <= pwdata[15:0];
                pwcb_pkg::REG_CLIP_TOP:      r_cfg.clip_top      <= pwdata[15:0];
                pwcb_pkg::REG_CLIP_WIDTH:    r_cfg.clip_width    <= pwdata[15:0];
                pwcb_pkg::REG_CLIP_HEIGHT:   r_cfg.clip_height   <= pwdata[15:0];
                pwcb_pkg::REG_MODE_BITS:     r_cfg.mode_bits     <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            pwcb_pkg::REG_SCREEN_WIDTH:  prdata = {19'd0, r_cfg.screen_width};
            pwcb_pkg::REG_SCREEN_HEIGHT: prdata = {19'd0, r_cfg.screen_height};
            pwcb_pkg::REG_ROW_PITCH:     prdata = {18'd0, r_cfg.row_pitch};
            pwcb_pkg::REG_CLIP_LEFT:     prdata = {16'd0, r_cfg.clip_left};
            pwcb_pkg::REG_CLIP_TOP:      prdata = {16'd0, r_cfg.clip_top};
            pwcb_pkg::REG_CLIP_WIDTH:    prdata = {16'd0, r_cfg.clip_width};
            pwcb_pkg::REG_CLIP_HEIGHT:   prdata = {16'd0, r_cfg.clip_height};
            pwcb_pkg::REG_MODE_BITS:     prdata = {30'd0, r_cfg.mode_bits};
            default:                     prdata = '0;
        endcase
    end

    pwcb_front #(
        .MAX_DIM   (MAX_DIM),
        .MAX_PITCH (MAX_PITCH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_pos_x      (s_axis_tdata[15:0]),
        .i_pos_y      (s_axis_tdata[31:16]),
        .i_src_color  (s_axis_tdata[63:32]),
        .i_dest_pixel (s_axis_tdata[95:64]),
        .o_valid      (w_f_valid),
        .i_ready      (w_f_ready),
        .o_item       (w_f_item)
    );

    pwcb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_item  (w_f_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    pwcb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_q_valid),
        .o_ready        (w_q_ready),
        .i_item         (w_q_item),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_write_enable (w_we),
        .o_word_address (w_addr),
        .o_write_data   (w_data)
    );

    assign m_axis_tuser = w_we;
    assign m_axis_tdata = {7'd0, w_data, w_addr};

endmodule

### tb/pixel_write_clip_blend_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_write_clip_blend_checker
// Watches the request, write and register channels of the pixel write block.
// Keeps its own copy of the registers, works out the framebuffer write due
// for every accepted request and compares it field by field with the words
// that leave the block, in order.
// ----------------------------------------------------------------------------
module pixel_write_clip_blend_checker #(
    parameter int MAX_DIM   = 4096,
    parameter int MAX_PITCH = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // pos_x, pos_y, src_color, dest_pixel
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,   // word_address, write_data, zero pad
    input  logic        m_axis_tuser,   // write_enable
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_mismatches,
    output int          o_outstanding
);

    typedef struct packed {
        logic        enable;
        logic [24:0] addr;
        logic [31:0] data;
    } t_pixel_write;

    t_pixel_write   pending_writes[$];
    t_pixel_write   want;
    pwcb_pkg::t_cfg regs;

    function automatic logic [7:0] mix_channel(logic [7:0] fg, logic [7:0] bg,
                                               logic [7:0] alpha);
        int unsigned total;
        total = 32'(fg) * 32'(alpha) + 32'(bg) * (32'd255 - 32'(alpha));
        return 8'(total / 255);
    endfunction

    function automatic t_pixel_write predict_write(logic [95:0] req);
        int           x, y, w, h, pitch, cl, ct, cr, cb;
        logic [31:0]  src, dst;
        logic [7:0]   alpha;
        logic         keep;
        t_pixel_write res;
        x = $signed(req[15:0]);
        y = $signed(req[31:16]);
        src = req[63:32];
        dst = req[95:64];
        alpha = src[31:24];
        w = int'(regs.screen_width);
        h = int'(regs.screen_height);
        pitch = int'(regs.row_pitch);
        if (w > MAX_DIM) w = MAX_DIM;
        if (h > MAX_DIM) h = MAX_DIM;
        if (pitch > MAX_PITCH) pitch = MAX_PITCH;
        keep = !(x < 0 || y < 0 || x >= w || y >= h);
        if (keep && regs.mode_bits[pwcb_pkg::MODE_CLIP]) begin
            cl = $signed(regs.clip_left);
            ct = $signed(regs.clip_top);
            cr = $signed(regs.clip_width);
            cb = $signed(regs.clip_height);
            cr += cl;
            cb += ct;
            if (x < cl || y < ct || x >= cr || y >= cb) keep = 1'b0;
        end
        res = '0;
        if (!keep) return res;
        res.enable = 1'b1;
        res.addr = 25'(y * pitch + x);
        if (regs.mode_bits[pwcb_pkg::MODE_BLEND] && alpha != pwcb_pkg::ALPHA_OPAQUE) begin
            if (alpha == pwcb_pkg::ALPHA_CLEAR) begin
                res.data = dst;
            end else begin
                res.data = pwcb_pkg::OPAQUE_MASK
                         | {8'h00, mix_channel(src[23:16], dst[23:16], alpha),
                            mix_channel(src[15:8], dst[15:8], alpha),
                            mix_channel(src[7:0], dst[7:0], alpha)};
            end
        end else begin
            res.data = src;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $time, what);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs = '0;
            pending_writes.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_writes.size() == 0) begin
                    report_mismatch($sformatf("write word with no request pending, tdata %h",
                                              m_axis_tdata));
                end else begin
                    want = pending_writes.pop_front();
                    if (m_axis_tuser !== want.enable)
                        report_mismatch($sformatf("write_enable %b, want %b",
                                                  m_axis_tuser, want.enable));
                    if (m_axis_tdata[24:0] !== want.addr)
                        report_mismatch($sformatf("word_address %h, want %h",
                                                  m_axis_tdata[24:0], want.addr));
                    if (m_axis_tdata[56:25] !== want.data)
                        report_mismatch($sformatf("write_data %h, want %h",
                                                  m_axis_tdata[56:25], want.data));
                    if (m_axis_tdata[63:57] !== 7'd0)
                        report_mismatch($sformatf("pad bits %h, want 0",
                                                  m_axis_tdata[63:57]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_writes.push_back(predict_write(s_axis_tdata));
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    pwcb_pkg::REG_SCREEN_WIDTH:  regs.screen_width  = pwdata[12:0];
                    pwcb_pkg::REG_SCREEN_HEIGHT: regs.screen_height = pwdata[12:0];
                    pwcb_pkg::REG_ROW_PITCH:     regs.row_pitch     = pwdata[13:0];
                    pwcb_pkg::REG_CLIP_LEFT:     regs.clip_left     = pwdata[15:0];
                    pwcb_pkg::REG_CLIP_TOP:      regs.clip_top      = pwdata[15:0];
                    pwcb_pkg::REG_CLIP_WIDTH:    regs.clip_width    = pwdata[15:0];
                    pwcb_pkg::REG_CLIP_HEIGHT:   regs.clip_height   = pwdata[15:0];
                    pwcb_pkg::REG_MODE_BITS:     regs.mode_bits     = pwdata[1:0];
                    default: ;
                endcase
            end
        end
        o_outstanding <= pending_writes.size();
    end

endmodule

### tb/pixel_write_clip_blend_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_write_clip_blend_test
// Drives pixel write requests into the block under a series of register
// settings: a directed pass over the screen and clip edges and every alpha
// case, then random phases with bursty requests and a stalling write side.
// Registers change only once the block has drained. The checker beside the
// block predicts and compares every write word.
// ----------------------------------------------------------------------------
module pixel_write_clip_blend_test;

    typedef struct {
        int         width;
        int         height;
        int         pitch;
        int         left;
        int         top;
        int         clip_w;
        int         clip_h;
        logic [1:0] mode;
    } t_setting;

    localparam int PHASE_WORDS = 140;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;    // pos_x, pos_y, src_color, dest_pixel
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [63:0] m_axis_tdata;         // word_address, write_data, zero pad
    logic        m_axis_tuser;         // write_enable
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          outstanding;

    int          stall_mode = 0;
    int          stall_left = 0;
    int          gap_mode;
    int          burst_left;
    logic [95:0] directed[$];
    t_setting    cur;

    always #5 i_clk = ~i_clk;

    pixel_write_clip_blend DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    pixel_write_clip_blend_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Write side: hold ready low for runs whose density follows stall_mode.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_mode != 0 &&
                     $urandom_range(0, (stall_mode == 1) ? 5 : 2) == 0) begin
            stall_left <= $urandom_range(0, (stall_mode == 1) ? 2 : 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [95:0] pixel_request(int x, int y, logic [31:0] src,
                                                  logic [31:0] dst);
        return {dst, src, y[15:0], x[15:0]};
    endfunction

    function automatic int near_edge(int edge_pos);
        return edge_pos + int'($urandom_range(0, 4)) - 2;
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(0, 9))
            0:       return 0;
            1, 2, 3: return $urandom_range(1, 32);
            4, 5, 6: return $urandom_range(1, 4096);
            7:       return 4096;
            8:       return 8191;
            default: return $urandom_range(4097, 8191);
        endcase
    endfunction

    function automatic t_setting random_setting();
        t_setting s;
        s.width = pick_dim();
        s.height = pick_dim();
        case ($urandom_range(0, 3))
            0:       s.pitch = s.width;
            1:       s.pitch = 8192;
            2:       s.pitch = $urandom_range(8193, 16383);
            default: s.pitch = $urandom_range(0, 8192);
        endcase
        if ($urandom_range(0, 4) == 0) begin
            s.left = $signed(16'($urandom));
            s.top = $signed(16'($urandom));
            s.clip_w = $signed(16'($urandom));
            s.clip_h = $signed(16'($urandom));
        end else begin
            s.left = int'($urandom_range(0, 80)) - 20;
            s.top = int'($urandom_range(0, 80)) - 20;
            s.clip_w = int'($urandom_range(0, 100)) - 10;
            s.clip_h = int'($urandom_range(0, 100)) - 10;
        end
        s.mode = 2'($urandom_range(0, 3));
        return s;
    endfunction

    function automatic logic [95:0] random_request(t_setting s);
        int          x, y;
        logic [31:0] src;
        case ($urandom_range(0, 19))
            0, 1, 2: begin
                x = $urandom;
                y = $urandom;
            end
            3, 4, 5: begin
                x = ($urandom_range(0, 1) == 0) ? near_edge(s.left)
                                                : near_edge(s.left + s.clip_w);
                y = ($urandom_range(0, 1) == 0) ? near_edge(s.top)
                                                : near_edge(s.top + s.clip_h);
            end
            default: begin
                x = int'($urandom_range(0, s.width + 7)) - 4;
                y = int'($urandom_range(0, s.height + 7)) - 4;
            end
        endcase
        src = $urandom;
        case ($urandom_range(0, 7))
            0:       src[31:24] = pwcb_pkg::ALPHA_CLEAR;
            1:       src[31:24] = pwcb_pkg::ALPHA_OPAQUE;
            2:       src[31:24] = 8'd1;
            3:       src[31:24] = 8'd254;
            default: ;
        endcase
        return pixel_request(x, y, src, $urandom);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_setting(t_setting s);
        write_reg(pwcb_pkg::REG_SCREEN_WIDTH, s.width);
        write_reg(pwcb_pkg::REG_SCREEN_HEIGHT, s.height);
        write_reg(pwcb_pkg::REG_ROW_PITCH, s.pitch);
        write_reg(pwcb_pkg::REG_CLIP_LEFT, s.left);
        write_reg(pwcb_pkg::REG_CLIP_TOP, s.top);
        write_reg(pwcb_pkg::REG_CLIP_WIDTH, s.clip_w);
        write_reg(pwcb_pkg::REG_CLIP_HEIGHT, s.clip_h);
        write_reg(pwcb_pkg::REG_MODE_BITS, int'(s.mode));
    endtask

    task automatic idle_cycles(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_word(logic [95:0] req);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_mode == 0) ? 0 : $urandom_range(0, 3 * gap_mode);
            if (gap > 0) idle_cycles(gap);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= req;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop valid and wait until every predicted write has come out.
    task automatic drain();
        idle_cycles(1);
        while (outstanding != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic run_random_phase(int words, bit hold_midway);
        for (int n = 0; n < words; n++) begin
            if (hold_midway && n == words / 2) drain();
            send_word(random_request(cur));
        end
        drain();
    endtask

    initial begin
        #5_000_000;
        $display("pixel_write_clip_blend_test: errors");
        $finish;
    end

    initial begin
        burst_left = 0;
        gap_mode = 1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // screen edges and alpha cases, blend on, clip off
        cur = '{640, 480, 1024, 100, 50, 200, 100, 2'b10};
        load_setting(cur);
        directed.push_back(pixel_request(0, 0, 32'hFF12_3456, 32'h0000_0000));
        directed.push_back(pixel_request(639, 479, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed.push_back(pixel_request(640, 0, 32'hFF00_0000, 32'h0000_0000));
        directed.push_back(pixel_request(0, 480, 32'hFF00_0000, 32'h0000_0000));
        directed.push_back(pixel_request(-1, 0, 32'hFF00_0000, 32'h0000_0000));
        directed.push_back(pixel_request(0, -1, 32'hFF00_0000, 32'h0000_0000));
        directed.push_back(pixel_request(-32768, -32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed.push_back(pixel_request(32767, 32767, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed.push_back(pixel_request(5, 5, 32'h00AB_CDEF, 32'h1234_5678));
        directed.push_back(pixel_request(6, 5, 32'h01FF_FFFF, 32'h0000_0000));
        directed.push_back(pixel_request(7, 5, 32'hFE10_2030, 32'hFFFF_FFFF));
        directed.push_back(pixel_request(8, 5, 32'h80FF_00FF, 32'h0000_FF00));
        directed.push_back(pixel_request(9, 5, 32'h0000_0000, 32'hFFFF_FFFF));
        foreach (directed[i]) send_word(directed[i]);
        drain();

        // clip rectangle edges, blend off
        directed.delete();
        cur.mode = 2'b01;
        write_reg(pwcb_pkg::REG_MODE_BITS, int'(cur.mode));
        directed.push_back(pixel_request(100, 50, 32'h1122_3344, 32'h5566_7788));
        directed.push_back(pixel_request(99, 50, 32'h1122_3344, 32'h5566_7788));
        directed.push_back(pixel_request(100, 49, 32'h1122_3344, 32'h5566_7788));
        directed.push_back(pixel_request(299, 149, 32'h1122_3344, 32'h5566_7788));
        directed.push_back(pixel_request(300, 149, 32'h1122_3344, 32'h5566_7788));
        directed.push_back(pixel_request(299, 150, 32'h1122_3344, 32'h5566_7788));
        directed.push_back(pixel_request(200, 100, 32'h00A0_B0C0, 32'hDEAD_BEEF));
        foreach (directed[i]) send_word(directed[i]);
        drain();

        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: cur = '{8191, 8191, 16383, -32768, -32768, 32767, 32767, 2'b10};
                1: cur = '{4096, 4096, 4096, -20000, -1, -20000, 32767, 2'b01};
                2: cur = '{0, 0, 0, 0, 0, 0, 0, 2'b00};
                3: cur = '{64, 48, 64, 32767, 32767, 32767, 32767, 2'b11};
                default: cur = random_setting();
            endcase
            stall_mode <= phase % 3;
            gap_mode = (phase % 4 == 1) ? 0 : 1 + phase % 3;
            load_setting(cur);
            run_random_phase(PHASE_WORDS, phase == 4);
        end

        if (mismatches == 0) begin
            $display("pixel_write_clip_blend_test: clean");
        end else begin
            $display("pixel_write_clip_blend_test: errors");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/pwcb_pkg.sv
rtl/core/pwcb_front.sv
rtl/core/pwcb_queue.sv
rtl/core/pwcb_back.sv
rtl/core/pixel_write_clip_blend.sv
tb/pixel_write_clip_blend_checker.sv
tb/pixel_write_clip_blend_test.sv
